// ----- rtl/frames_to_drop_frame_timecode_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef FRAMES_TO_DROP_FRAME_TIMECODE_MACROS_SVH
`define FRAMES_TO_DROP_FRAME_TIMECODE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FTDF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FTDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FTDF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FTDF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/ftdf_pkg.sv -----
package ftdf_pkg;
   localparam int COUNT_BITS = 22;
   localparam int ADJ_BITS = COUNT_BITS + 1;
   localparam int RATE_BITS = 7;
   localparam int HOURS_BITS = 11;
   localparam int MINS_BITS = 6;
   localparam int SECS_BITS = 6;
   localparam int FRAMES_BITS = 7;
   localparam int DIGIT_BITS = 4;

   localparam logic [RATE_BITS-1:0] RATE_RESET = 7'd30;
   localparam logic [RATE_BITS-1:0] DF_RATE = 7'd30;
   localparam logic [RATE_BITS-1:0] DF_ALIAS = 7'd29;
   localparam int DF_MINUTE = 1800;
   localparam int DF_GROUP = 17982;
   localparam int DF_STEP = 1798;
   localparam int DF_GROUP_ADD = 18;
   localparam int DF_DIGIT_MAX = 9;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN = 60;

   localparam longint CountMax = (64'(1) << COUNT_BITS) - 1;
   localparam longint AdjMax = (64'(1) << ADJ_BITS) - 1;
   localparam int GRP_BITS = $clog2(CountMax / DF_GROUP + 1);
   localparam int HQ_BITS = $clog2(AdjMax / SECS_PER_HOUR + 1);
   localparam int PH_BITS = $clog2(((1 << RATE_BITS) - 1) * SECS_PER_HOUR + 1);
   localparam int PM_BITS = $clog2(((1 << RATE_BITS) - 1) * SECS_PER_MIN + 1);

   typedef struct packed {
      logic                  valid;
      logic [RATE_BITS-1:0]  rate;
      logic                  drop;
      logic [ADJ_BITS-1:0]   count;
   } adj_item_type;

   typedef struct packed {
      logic                   valid;
      logic [RATE_BITS-1:0]   rate;
      logic                   drop;
      logic [HQ_BITS-1:0]     hours;
      logic [MINS_BITS-1:0]   mins;
      logic [SECS_BITS-1:0]   secs;
      logic [FRAMES_BITS-1:0] frames;
   } tc_item_type;
endpackage

// ----- rtl/ftdf_adjust.sv -----
module ftdf_adjust (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [ftdf_pkg::COUNT_BITS-1:0]  in_count,
   input  logic [ftdf_pkg::RATE_BITS-1:0]   in_rate,
   input  logic                             in_drop,
   output ftdf_pkg::adj_item_type           out_item
);
   import ftdf_pkg::*;

   localparam int NF = GRP_BITS + 3;

   typedef struct packed {
      logic [RATE_BITS-1:0]  rate;
      logic                  drop;
      logic                  late;
      logic [COUNT_BITS-1:0] count;
      logic [COUNT_BITS-1:0] rem;
      logic [GRP_BITS-1:0]   grp;
      logic [DIGIT_BITS-1:0] digit;
      logic [ADJ_BITS-1:0]   adj;
   } front_type;

   logic [NF-1:0] valid_ff, valid_in;
   front_type     st_ff [NF];
   front_type     st_in [NF];

   always_comb begin
      logic                  take;
      logic [DIGIT_BITS-1:0] dig;
      logic [ADJ_BITS-1:0]   extra;
      valid_in = {valid_ff[NF-2:0], in_valid};
      st_in[0].rate  = in_rate;
      st_in[0].drop  = in_drop;
      st_in[0].late  = in_drop && (in_count >= COUNT_BITS'(DF_MINUTE));
      st_in[0].count = in_count;
      st_in[0].rem   = st_in[0].late ? (in_count - COUNT_BITS'(DF_MINUTE)) : '0;
      st_in[0].grp   = '0;
      st_in[0].digit = '0;
      st_in[0].adj   = '0;
      for (int k = 1; k < NF; k++) begin
         st_in[k] = st_ff[k-1];
         take  = 1'b0;
         dig   = '0;
         extra = '0;
         if (k <= GRP_BITS) begin
            take = (st_ff[k-1].rem >> (GRP_BITS - k)) >= COUNT_BITS'(DF_GROUP);
            if (take) begin
               st_in[k].rem = st_ff[k-1].rem - (COUNT_BITS'(DF_GROUP) << (GRP_BITS - k));
            end
            st_in[k].grp = {st_ff[k-1].grp[GRP_BITS-2:0], take};
         end else if (k == GRP_BITS + 1) begin
            for (int i = 1; i <= DF_DIGIT_MAX; i++) begin
               if (st_ff[k-1].rem >= COUNT_BITS'(DF_STEP * i)) begin
                  dig = dig + DIGIT_BITS'(1);
               end
            end
            st_in[k].digit = dig;
         end else begin
            extra = ADJ_BITS'(st_ff[k-1].grp) * ADJ_BITS'(DF_GROUP_ADD)
                  + (ADJ_BITS'(st_ff[k-1].digit) << 1) + ADJ_BITS'(2);
            if (st_ff[k-1].digit == DIGIT_BITS'(DF_DIGIT_MAX)) begin
               extra = extra - ADJ_BITS'(2);
            end
            st_in[k].adj = ADJ_BITS'(st_ff[k-1].count)
                         + (st_ff[k-1].late ? extra : ADJ_BITS'(0));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign out_item.valid = valid_ff[NF-1];
   assign out_item.rate  = st_ff[NF-1].rate;
   assign out_item.drop  = st_ff[NF-1].drop;
   assign out_item.count = st_ff[NF-1].adj;
endmodule

// ----- rtl/ftdf_split.sv -----
module ftdf_split (
   input  logic                   clock,
   input  logic                   reset,
   input  ftdf_pkg::adj_item_type in_item,
   output ftdf_pkg::tc_item_type  out_item
);
   import ftdf_pkg::*;

   localparam int NS = 1 + HQ_BITS + MINS_BITS + SECS_BITS;

   typedef struct packed {
      logic [RATE_BITS-1:0] rate;
      logic                 drop;
      logic [PH_BITS-1:0]   per_hour;
      logic [PM_BITS-1:0]   per_min;
      logic [ADJ_BITS-1:0]  rem;
      logic [HQ_BITS-1:0]   hours;
      logic [MINS_BITS-1:0] mins;
      logic [SECS_BITS-1:0] secs;
   } split_type;

   logic [NS-1:0] valid_ff, valid_in;
   split_type     st_ff [NS];
   split_type     st_in [NS];

   always_comb begin
      logic take;
      valid_in = {valid_ff[NS-2:0], in_item.valid};
      st_in[0].rate     = in_item.rate;
      st_in[0].drop     = in_item.drop;
      st_in[0].per_hour = PH_BITS'(in_item.rate) * PH_BITS'(SECS_PER_HOUR);
      st_in[0].per_min  = PM_BITS'(in_item.rate) * PM_BITS'(SECS_PER_MIN);
      st_in[0].rem      = in_item.count;
      st_in[0].hours    = '0;
      st_in[0].mins     = '0;
      st_in[0].secs     = '0;
      for (int k = 1; k < NS; k++) begin
         st_in[k] = st_ff[k-1];
         take = 1'b0;
         if (k <= HQ_BITS) begin
            take = (st_ff[k-1].rem >> (HQ_BITS - k)) >= ADJ_BITS'(st_ff[k-1].per_hour);
            if (take) begin
               st_in[k].rem = st_ff[k-1].rem
                            - (ADJ_BITS'(st_ff[k-1].per_hour) << (HQ_BITS - k));
            end
            st_in[k].hours = {st_ff[k-1].hours[HQ_BITS-2:0], take};
         end else if (k <= HQ_BITS + MINS_BITS) begin
            take = (st_ff[k-1].rem >> (HQ_BITS + MINS_BITS - k))
                 >= ADJ_BITS'(st_ff[k-1].per_min);
            if (take) begin
               st_in[k].rem = st_ff[k-1].rem
                            - (ADJ_BITS'(st_ff[k-1].per_min) << (HQ_BITS + MINS_BITS - k));
            end
            st_in[k].mins = {st_ff[k-1].mins[MINS_BITS-2:0], take};
         end else begin
            take = (st_ff[k-1].rem >> (NS - 1 - k)) >= ADJ_BITS'(st_ff[k-1].rate);
            if (take) begin
               st_in[k].rem = st_ff[k-1].rem
                            - (ADJ_BITS'(st_ff[k-1].rate) << (NS - 1 - k));
            end
            st_in[k].secs = {st_ff[k-1].secs[SECS_BITS-2:0], take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign out_item.valid  = valid_ff[NS-1];
   assign out_item.rate   = st_ff[NS-1].rate;
   assign out_item.drop   = st_ff[NS-1].drop;
   assign out_item.hours  = st_ff[NS-1].hours;
   assign out_item.mins   = st_ff[NS-1].mins;
   assign out_item.secs   = st_ff[NS-1].secs;
   assign out_item.frames = st_ff[NS-1].rem[FRAMES_BITS-1:0];
endmodule

// ----- rtl/frames_to_drop_frame_timecode.sv -----
// A result strobes on rsp_valid after its start passes the adjust and split stages and the output register.
// Throughput: one transaction per cycle; the bit-per-stage dividers of the
// drop-frame adjustment and of the hour, minute and second split set the depth.
// busy stays low, and csr_ready stays high; results cannot be held off.
// Synchronous reset empties the pipeline and sets the frame rate to 30.
`include "frames_to_drop_frame_timecode_macros.svh"
module frames_to_drop_frame_timecode (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ftdf_pkg::COUNT_BITS-1:0]    req_frame_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ftdf_pkg::RATE_BITS-1:0]     csr_frames_per_second,
   output logic                               rsp_valid,
   output logic [ftdf_pkg::HOURS_BITS-1:0]    rsp_tc_hours,
   output logic [ftdf_pkg::MINS_BITS-1:0]     rsp_tc_minutes,
   output logic [ftdf_pkg::SECS_BITS-1:0]     rsp_tc_seconds,
   output logic [ftdf_pkg::FRAMES_BITS-1:0]   rsp_tc_frames,
   output logic                               rsp_drop_frame
);
   import ftdf_pkg::*;

   logic [RATE_BITS-1:0]   rate_ff, rate_in;
   logic [RATE_BITS-1:0]   rate_eff;
   adj_item_type           adj_item;
   tc_item_type            tc_item;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HOURS_BITS-1:0]  hours_ff, hours_in;
   logic [MINS_BITS-1:0]   mins_ff, mins_in;
   logic [SECS_BITS-1:0]   secs_ff, secs_in;
   logic [FRAMES_BITS-1:0] frames_ff, frames_in;
   logic                   drop_ff, drop_in;
   logic                   live;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign rate_in   = (csr_valid && csr_ready) ? csr_frames_per_second : rate_ff;
   assign rate_eff  = (rate_ff == DF_ALIAS) ? DF_RATE : rate_ff;

   ftdf_adjust u_adjust (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_count (req_frame_count),
      .in_rate  (rate_eff),
      .in_drop  (rate_eff == DF_RATE),
      .out_item (adj_item)
   );

   ftdf_split u_split (
      .clock    (clock),
      .reset    (reset),
      .in_item  (adj_item),
      .out_item (tc_item)
   );

   always_comb begin
      live         = tc_item.rate != '0;
      rsp_valid_in = tc_item.valid;
      hours_in     = live ? tc_item.hours[HOURS_BITS-1:0] : '0;
      mins_in      = live ? tc_item.mins : '0;
      secs_in      = live ? tc_item.secs : '0;
      frames_in    = live ? tc_item.frames : '0;
      drop_in      = tc_item.drop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hours_ff  <= hours_in;
      mins_ff   <= mins_in;
      secs_ff   <= secs_in;
      frames_ff <= frames_in;
      drop_ff   <= drop_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tc_hours   = hours_ff;
   assign rsp_tc_minutes = mins_ff;
   assign rsp_tc_seconds = secs_ff;
   assign rsp_tc_frames  = frames_ff;
   assign rsp_drop_frame = drop_ff;

   `FTDF_ASSERT_IMPL(a_clock_fields, clock, reset, rsp_valid, (rsp_tc_minutes < MINS_BITS'(SECS_PER_MIN)) && (rsp_tc_seconds < SECS_BITS'(SECS_PER_MIN)))
   `FTDF_ASSERT_IMPL(a_drop_frames, clock, reset, rsp_valid && rsp_drop_frame, rsp_tc_frames < FRAMES_BITS'(DF_RATE))
   `FTDF_ASSERT_IMPL(a_drop_rate, clock, reset, rsp_valid && rsp_drop_frame, (rate_ff == DF_RATE) || (rate_ff == DF_ALIAS))
   `FTDF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
endmodule
